>>> rtl/core/rv32i_instruction_step_assert.svh
// Assertion macros used by the checker of the RV32I step core.
// Depends on nothing; included by rvis_checker.sv.
`ifndef RV32I_INSTRUCTION_STEP_ASSERT_SVH
`define RV32I_INSTRUCTION_STEP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define RVIS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvis: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define RVIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvis: next-cycle check failed");

`endif

>>> rtl/core/rvis_pkg.sv
// Shared types, codes and the integer ALU function for the RV32I step core.
// Depends on nothing.
`default_nettype none
package rvis_pkg;

   // Result status codes.
   localparam logic [2:0] ST_LOADED     = 3'd0;
   localparam logic [2:0] ST_CONTINUE   = 3'd1;
   localparam logic [2:0] ST_HALTED     = 3'd2;
   localparam logic [2:0] ST_UNKNOWN    = 3'd3;
   localparam logic [2:0] ST_MISALIGNED = 3'd4;
   localparam logic [2:0] ST_LIMIT      = 3'd5;

   // Major opcodes.
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_IMM    = 7'h13;
   localparam logic [6:0] OPC_REG    = 7'h33;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // ALU function codes.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // Branch conditions.
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // Load and store widths.
   localparam logic [2:0] F3_B  = 3'd0;
   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_BU = 3'd4;
   localparam logic [2:0] F3_HU = 3'd5;

   // Privileged group of the system opcode.
   localparam logic [2:0] F3_PRIV = 3'd0;

   // Configuration register indexes.
   localparam logic CSR_START_ADDRESS = 1'b0;
   localparam logic CSR_STEP_LIMIT    = 1'b1;

   localparam logic [31:0] STEP_LIMIT_RESET = 32'd1000000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic decode;
      logic execute;
      logic mem_done;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic early_stop;
      logic need_mem;
      logic out_free;
   } stat_type;

   // Integer ALU shared by register and immediate operations.
   function automatic logic [31:0] alu_calc(input logic [2:0] f3, input logic alt,
                                           input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      unique case (f3)
         F3_ADD:  r = alt ? (a - b) : (a + b);
         F3_SLL:  r = a << b[4:0];
         F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
         F3_SLTU: r = {31'd0, a < b};
         F3_XOR:  r = a ^ b;
         F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : (a >> b[4:0]);
         F3_OR:   r = a | b;
         F3_AND:  r = a & b;
         default: r = a & b;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/rvis_ctrl.sv
// Sequencing state machine of the RV32I step core.
// Depends on rvis_pkg; drives the datapath rvis_dp through cmd_type.
`default_nettype none
module rvis_ctrl
   import rvis_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_action,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DEC   = 3'd2;
   localparam logic [2:0] S_EXE   = 3'd3;
   localparam logic [2:0] S_MEM   = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   logic [2:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = req_action ? S_DEC : S_FIN;
            end
         end
         S_DEC: begin
            cmd.decode = 1'b1;
            state_in   = stat.early_stop ? S_FIN : S_EXE;
         end
         S_EXE: begin
            cmd.execute = 1'b1;
            state_in    = stat.need_mem ? S_MEM : S_FIN;
         end
         S_MEM: begin
            cmd.mem_done = 1'b1;
            state_in     = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/rvis_dp.sv
// Datapath of the RV32I step core: byte-lane memory, register file, ALU and
// architectural state. Depends on rvis_pkg; sequenced by rvis_ctrl.
`default_nettype none
module rvis_dp
   import rvis_pkg::*;
#(
   parameter int MEM_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic        req_action,
   input  wire logic [15:0] req_load_address,
   input  wire logic [31:0] req_load_data,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_program_counter,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic [31:0]      rsp_steps_done
);

   localparam int AW    = $clog2(MEM_BYTES);
   localparam int WW    = AW - 2;
   localparam int WORDS = MEM_BYTES / 4;

   // Architectural and configuration state.
   logic [31:0] pc_ff, cnt_ff, limit_ff;
   logic [15:0] start_ff;
   logic [2:0]  stop_ff;
   logic [WW-1:0] sweep_ff;

   // Per-item working registers.
   logic [31:0] inst_ff, a_ff, b_ff;
   logic [1:0]  rd_off_ff;
   logic [2:0]  res_status_ff;
   logic [31:0] res_pc_ff, res_val_ff;
   logic        res_wr_ff;
   logic [4:0]  res_idx_ff;
   logic [3:0]  st_mask_ff;
   logic [AW-1:0] st_base_ff;
   logic [31:0] st_data_ff;
   logic        rsp_valid_ff;

   // Word index in lane j of the byte that lane holds for an access at base.
   function automatic logic [WW-1:0] lane_index(input logic [AW-1:0] base,
                                                input logic [1:0] j);
      logic [1:0]    k;
      logic [AW-1:0] s;
      k = j - base[1:0];
      s = base + AW'(k);
      return s[AW-1:2];
   endfunction

   // Byte lanes: four one-write, one-read memories with registered read data.
   logic [WW-1:0] lraddr [4];
   logic [WW-1:0] lwaddr [4];
   logic [7:0]    lwdata [4];
   logic [3:0]    lwe;
   logic [7:0]    lrd    [4];

   for (genvar j = 0; j < 4; j++) begin : g_lane
      logic [7:0] mem [WORDS];
      always_ff @(posedge clock) begin
         if (lwe[j]) mem[lwaddr[j]] <= lwdata[j];
         lrd[j] <= mem[lraddr[j]];
      end
   end

   // Instruction fields of the held instruction.
   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, ld_addr, st_addr;
   assign opc   = inst_ff[6:0];
   assign rd    = inst_ff[11:7];
   assign f3    = inst_ff[14:12];
   assign imm_i = {{20{inst_ff[31]}}, inst_ff[31:20]};
   assign imm_s = {{20{inst_ff[31]}}, inst_ff[31:25], inst_ff[11:7]};
   assign imm_b = {{19{inst_ff[31]}}, inst_ff[31], inst_ff[7], inst_ff[30:25],
                   inst_ff[11:8], 1'b0};
   assign imm_j = {{11{inst_ff[31]}}, inst_ff[31], inst_ff[19:12], inst_ff[20],
                   inst_ff[30:21], 1'b0};
   assign imm_u = {inst_ff[31:12], 12'd0};
   assign ld_addr = a_ff + imm_i;
   assign st_addr = a_ff + imm_s;

   // Memory read and write addressing.
   logic [AW-1:0] rd_base;
   logic [31:0]   rword;
   logic          rf_clear;
   assign rd_base  = cmd.execute ? ld_addr[AW-1:0] : pc_ff[AW-1:0];
   assign rf_clear = cmd.clear_wr && (sweep_ff < WW'(32));

   always_comb begin
      logic [1:0] lo;
      for (int j = 0; j < 4; j++) begin
         lraddr[j] = lane_index(rd_base, 2'(j));
         // Byte offset within the stored word that lands in this lane.
         lo = 2'(j) - st_base_ff[1:0];
         if (cmd.clear_wr) begin
            lwaddr[j] = sweep_ff;
            lwdata[j] = 8'd0;
            lwe[j]    = 1'b1;
         end else begin
            lwaddr[j] = lane_index(st_base_ff, 2'(j));
            lwdata[j] = st_data_ff[{lo, 3'b000} +: 8];
            lwe[j]    = cmd.commit && st_mask_ff[lo];
         end
      end
      for (int k = 0; k < 4; k++) begin
         rword[8*k +: 8] = lrd[2'(k) + rd_off_ff];
      end
   end

   // Register file, two registered read ports and one write port.
   logic [31:0] rf [32];
   logic [31:0] rs_word;
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [31:0] rf_wd;
   assign rs_word = cmd.decode ? rword : inst_ff;
   assign rf_we   = rf_clear || (cmd.commit && res_wr_ff);
   assign rf_wa   = rf_clear ? sweep_ff[4:0] : res_idx_ff;
   assign rf_wd   = rf_clear ? 32'd0 : res_val_ff;

   always_ff @(posedge clock) begin
      if (rf_we) rf[rf_wa] <= rf_wd;
      a_ff <= rf[rs_word[19:15]];
      b_ff <= rf[rs_word[24:20]];
   end

   // Checks ahead of execution: sticky stop, step limit, fetch alignment.
   logic [2:0] early_status;
   always_comb begin
      priority if (stop_ff != ST_LOADED) early_status = stop_ff;
      else if (cnt_ff >= limit_ff)       early_status = ST_LIMIT;
      else                               early_status = ST_MISALIGNED;
   end

   // Execution of one instruction.
   logic [2:0]  e_status;
   logic [31:0] e_npc, e_val;
   logic        e_write, e_need_mem, e_take, e_alt;
   logic [3:0]  e_mask;
   always_comb begin
      e_status   = ST_CONTINUE;
      e_npc      = pc_ff + 32'd4;
      e_val      = 32'd0;
      e_write    = 1'b0;
      e_need_mem = 1'b0;
      e_mask     = 4'b0000;
      e_take     = 1'b0;
      e_alt      = 1'b0;
      unique case (opc)
         OPC_LUI: begin
            e_val = imm_u; e_write = 1'b1;
         end
         OPC_AUIPC: begin
            e_val = pc_ff + imm_u; e_write = 1'b1;
         end
         OPC_JAL: begin
            e_val = pc_ff + 32'd4; e_write = 1'b1; e_npc = pc_ff + imm_j;
         end
         OPC_JALR: begin
            e_val = pc_ff + 32'd4; e_write = 1'b1; e_npc = ld_addr & ~32'd1;
         end
         OPC_BRANCH: begin
            unique case (f3)
               F3_BEQ:  e_take = (a_ff == b_ff);
               F3_BNE:  e_take = (a_ff != b_ff);
               F3_BLT:  e_take = ($signed(a_ff) < $signed(b_ff));
               F3_BGE:  e_take = ($signed(a_ff) >= $signed(b_ff));
               F3_BLTU: e_take = (a_ff < b_ff);
               F3_BGEU: e_take = (a_ff >= b_ff);
               default: e_take = 1'b0;
            endcase
            if (e_take) e_npc = pc_ff + imm_b;
         end
         OPC_LOAD: begin
            unique case (f3)
               F3_B, F3_H, F3_BU, F3_HU: e_need_mem = 1'b1;
               F3_W: begin
                  if (ld_addr[1:0] != 2'd0) e_status = ST_MISALIGNED;
                  else                      e_need_mem = 1'b1;
               end
               default: e_need_mem = 1'b0;
            endcase
         end
         OPC_STORE: begin
            unique case (f3)
               F3_B: e_mask = 4'b0001;
               F3_H: e_mask = 4'b0011;
               F3_W: begin
                  if (st_addr[1:0] != 2'd0) e_status = ST_MISALIGNED;
                  else                      e_mask = 4'b1111;
               end
               default: e_mask = 4'b0000;
            endcase
         end
         OPC_IMM: begin
            e_alt   = (f3 == F3_SR) && inst_ff[30];
            e_val   = alu_calc(f3, e_alt, a_ff, imm_i);
            e_write = 1'b1;
         end
         OPC_REG: begin
            e_alt   = ((f3 == F3_ADD) || (f3 == F3_SR)) && inst_ff[30];
            e_val   = alu_calc(f3, e_alt, a_ff, b_ff);
            e_write = 1'b1;
         end
         OPC_SYSTEM: begin
            if ((f3 == F3_PRIV) && (inst_ff[31:20] <= 12'd1)) e_status = ST_HALTED;
         end
         default: e_status = ST_UNKNOWN;
      endcase
   end

   // Load result from the assembled memory word.
   logic [31:0] m_val;
   always_comb begin
      unique case (f3)
         F3_B:    m_val = {{24{rword[7]}}, rword[7:0]};
         F3_H:    m_val = {{16{rword[15]}}, rword[15:0]};
         F3_BU:   m_val = {24'd0, rword[7:0]};
         F3_HU:   m_val = {16'd0, rword[15:0]};
         default: m_val = rword;
      endcase
   end

   logic [31:0] load_base;
   assign load_base = {16'd0, req_load_address[15:2], 2'b00};

   // Working registers, updated phase by phase.
   always_ff @(posedge clock) begin
      rd_off_ff <= rd_base[1:0];
      if (cmd.accept && !req_action) begin
         res_status_ff <= ST_LOADED;
         res_pc_ff     <= {16'd0, start_ff};
         res_wr_ff     <= 1'b0;
         res_idx_ff    <= 5'd0;
         res_val_ff    <= 32'd0;
         st_mask_ff    <= 4'b1111;
         st_base_ff    <= load_base[AW-1:0];
         st_data_ff    <= req_load_data;
      end
      if (cmd.decode) begin
         inst_ff       <= rword;
         res_status_ff <= early_status;
         res_pc_ff     <= pc_ff;
         res_wr_ff     <= 1'b0;
         res_idx_ff    <= 5'd0;
         res_val_ff    <= 32'd0;
         st_mask_ff    <= 4'b0000;
      end
      if (cmd.execute) begin
         res_status_ff <= e_status;
         if (e_status == ST_CONTINUE) begin
            res_pc_ff  <= e_npc;
            res_wr_ff  <= e_write && (rd != 5'd0);
            res_idx_ff <= (e_write && (rd != 5'd0)) ? rd : 5'd0;
            res_val_ff <= (e_write && (rd != 5'd0)) ? e_val : 32'd0;
            st_mask_ff <= e_mask;
         end
         st_base_ff <= st_addr[AW-1:0];
         st_data_ff <= b_ff;
      end
      if (cmd.mem_done) begin
         res_wr_ff  <= (rd != 5'd0);
         res_idx_ff <= rd;
         res_val_ff <= (rd != 5'd0) ? m_val : 32'd0;
      end
      if (cmd.commit) begin
         rsp_status          <= res_status_ff;
         rsp_program_counter <= res_pc_ff;
         rsp_reg_written     <= res_wr_ff;
         rsp_reg_index       <= res_idx_ff;
         rsp_reg_value       <= res_val_ff;
         priority if (res_status_ff == ST_LOADED)   rsp_steps_done <= 32'd0;
         else if (res_status_ff == ST_CONTINUE)     rsp_steps_done <= cnt_ff + 32'd1;
         else                                       rsp_steps_done <= cnt_ff;
      end
   end

   // Architectural state, configuration, clearing sweep and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= 32'd0;
         cnt_ff       <= 32'd0;
         stop_ff      <= ST_LOADED;
         start_ff     <= 16'd0;
         limit_ff     <= STEP_LIMIT_RESET;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_START_ADDRESS: start_ff <= csr_write_data[15:0];
               CSR_STEP_LIMIT:    limit_ff <= csr_write_data;
               default:           limit_ff <= csr_write_data;
            endcase
         end
         if (cmd.clear_wr) sweep_ff <= sweep_ff + 1'b1;
         if (cmd.commit) begin
            priority if (res_status_ff == ST_LOADED) begin
               pc_ff   <= res_pc_ff;
               cnt_ff  <= 32'd0;
               stop_ff <= ST_LOADED;
            end else if (res_status_ff == ST_CONTINUE) begin
               pc_ff  <= res_pc_ff;
               cnt_ff <= cnt_ff + 32'd1;
            end else begin
               stop_ff <= res_status_ff;
            end
         end
         rsp_valid_ff <= cmd.commit || (rsp_valid_ff && !rsp_ready);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign stat.clear_last = (sweep_ff == {WW{1'b1}});
   assign stat.early_stop = (stop_ff != ST_LOADED) || (cnt_ff >= limit_ff)
                            || (pc_ff[1:0] != 2'd0);
   assign stat.need_mem   = (e_status == ST_CONTINUE) && e_need_mem;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

>>> rtl/core/rv32i_instruction_step.sv
// Top level of the RV32I step core: controller plus datapath.
// Depends on rvis_pkg, rvis_ctrl and rvis_dp.
//
//   Port group | Direction | Handshake           | Carries
//   req_*      | in        | req_valid/req_ready | action, load address, load data
//   rsp_*      | out       | rsp_valid/rsp_ready | status, pc, register write, steps
//   csr_*      | in        | csr_write_enable    | start address, step limit
//
// A load item passes through the idle and finish states; a step item through idle,
// decode, execute and finish, with a memory state before finish for a load, and it
// skips execute when the core is stopped, at its limit or fetching from a misaligned pc.
// The states follow the registered reads of the byte-lane memory and the register file, with the commit in finish.
// After reset the memory is cleared one word per cycle before the first transfer is
// taken; MEM_BYTES must be a power of two.
// A finished result waits in the output register; the commit stalls until it is taken.
`default_nettype none
module rv32i_instruction_step
   import rvis_pkg::*;
#(
   parameter int MEM_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [15:0] req_load_address,
   input  wire logic [31:0] req_load_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_program_counter,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic [31:0]      rsp_steps_done,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   rvis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath and state.
   rvis_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_action          (req_action),
      .req_load_address    (req_load_address),
      .req_load_data       (req_load_data),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_program_counter (rsp_program_counter),
      .rsp_reg_written     (rsp_reg_written),
      .rsp_reg_index       (rsp_reg_index),
      .rsp_reg_value       (rsp_reg_value),
      .rsp_steps_done      (rsp_steps_done)
   );

endmodule
`default_nettype wire

>>> rtl/core/rvis_checker.sv
// Port-level checks on the RV32I step core, bound to its top level.
// Depends on rvis_pkg and rv32i_instruction_step_assert.svh.
`default_nettype none
`include "rv32i_instruction_step_assert.svh"
module rvis_checker
   import rvis_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_action,
   input wire logic [15:0] req_load_address,
   input wire logic [31:0] req_load_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_program_counter,
   input wire logic        rsp_reg_written,
   input wire logic [4:0]  rsp_reg_index,
   input wire logic [31:0] rsp_reg_value,
   input wire logic [31:0] rsp_steps_done,
   input wire logic        csr_write_enable,
   input wire logic        csr_index,
   input wire logic [31:0] csr_write_data
);

   // A result that has not been taken stays offered.
   `RVIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A load transfer restarts the step count and writes no register.
   `RVIS_ASSERT_IMPL(a_load_rsp, clock, reset, rsp_valid && (rsp_status == ST_LOADED), (rsp_steps_done == 32'd0) && !rsp_reg_written)

   // Without a register write the index and value read as zero.
   `RVIS_ASSERT_IMPL(a_no_wr_zero, clock, reset, rsp_valid && !rsp_reg_written, (rsp_reg_index == 5'd0) && (rsp_reg_value == 32'd0))

   // A stop status never comes with a register write.
   `RVIS_ASSERT_IMPL(a_stop_no_wr, clock, reset, rsp_valid && ((rsp_status == ST_HALTED) || (rsp_status == ST_UNKNOWN) || (rsp_status == ST_MISALIGNED) || (rsp_status == ST_LIMIT)), !rsp_reg_written)

endmodule

bind rv32i_instruction_step rvis_checker u_rvis_checker (.*);
`default_nettype wire
